@@ hw/rtl/hrhp_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser package
// Shared item types, status codes and method tables for the head parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

   localparam int OFFSET_BITS_DEFAULT    = 16;
   localparam int MAX_METHOD_LEN_DEFAULT = 7;

   localparam int OFFSET_PORT_BITS = 16;
   localparam int MARK_BITS        = 20;
   localparam int METHOD_COUNT     = 8;

   localparam logic [2:0] ST_MORE = 3'd0;
   localparam logic [2:0] ST_LINE = 3'd1;
   localparam logic [2:0] ST_HDR  = 3'd2;
   localparam logic [2:0] ST_HEAD = 3'd3;
   localparam logic [2:0] ST_FAIL = 3'd4;

   // Lower-case method names, first character in the lowest byte.
   localparam logic [63:0] METHOD_WORDS [METHOD_COUNT] = '{
      64'h0000_0000_0074_6567,
      64'h0000_0000_7473_6F70,
      64'h0000_0000_0074_7570,
      64'h0000_0000_6461_6568,
      64'h0000_6574_656C_6564,
      64'h0073_6E6F_6974_706F,
      64'h0000_0065_6361_7274,
      64'h0074_6365_6E6E_6F63
   };

   localparam logic [3:0] METHOD_LENS [METHOD_COUNT] = '{
      4'd3, 4'd4, 4'd3, 4'd4, 4'd6, 4'd7, 4'd5, 4'd7
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [2:0]                  status;
      logic [3:0]                  method_code;
      logic [OFFSET_PORT_BITS-1:0] byte_offset;
      logic [MARK_BITS-1:0]        boundary_marks;
   } rsp_type;

endpackage

@@ hw/rtl/hrhp_parser.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser state machine
// Holds the parse state and computes the result for the byte being accepted.
// ----------------------------------------------------------------------------
module hrhp_parser #(
   parameter int OFFSET_BITS    = hrhp_pkg::OFFSET_BITS_DEFAULT,
   parameter int MAX_METHOD_LEN = hrhp_pkg::MAX_METHOD_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  hrhp_pkg::req_type req,
   output hrhp_pkg::rsp_type result
);

   localparam int MB_W = 8 * MAX_METHOD_LEN;
   localparam int ML_W = $clog2(MAX_METHOD_LEN + 2);
   localparam int MK_W = hrhp_pkg::MARK_BITS;

   localparam int FK_METHOD  = 0;
   localparam int FK_URI     = 1;
   localparam int FK_SCHEMA  = 2;
   localparam int FK_HOST    = 3;
   localparam int FK_PORT    = 4;
   localparam int FK_PATH    = 5;
   localparam int FK_QUERY   = 6;
   localparam int FK_VERSION = 7;
   localparam int FK_KEY     = 8;
   localparam int FK_VALUE   = 9;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CASE_BIT = 8'h20;

   typedef enum logic [4:0] {
      S_LINE_START, S_METHOD, S_AFTER_METHOD, S_SCHEMA, S_SLASH1, S_SLASH2,
      S_HOST, S_PORT, S_PATH, S_QUERY, S_VER_START, S_VER_H, S_VER_HT,
      S_VER_HTT, S_VER_HTTP, S_VER_SLASH, S_VER_MAJOR, S_VER_DOT, S_VER_MINOR,
      S_LINE_CR, S_KEY, S_COLON, S_COLON_SP, S_VALUE, S_VAL_CR, S_AFTER_LF,
      S_BLANK_CR
   } state_type;

   function automatic logic [MK_W-1:0] ms(input int k);
      ms = MK_W'(1) << (2 * k);
   endfunction

   function automatic logic [MK_W-1:0] me(input int k);
      me = MK_W'(1) << (2 * k + 1);
   endfunction

   function automatic logic is_upper(input logic [7:0] b);
      is_upper = (b >= 8'h41) && (b <= 8'h5A);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      is_alpha = is_upper(b) || ((b >= 8'h61) && (b <= 8'h7A));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      is_digit = (b >= 8'h30) && (b <= 8'h39);
   endfunction

   state_type              state_ff, state_in, cur_state;
   logic [MB_W-1:0]        mbytes_ff, mbytes_in, cur_mbytes, kept_mbytes;
   logic [ML_W-1:0]        mlen_ff, mlen_in, cur_mlen, kept_mlen;
   logic [MK_W-1:0]        pend_ff, pend_in, cur_pend;
   logic [3:0]             found_ff, found_in, cur_found, match_code;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in, cur_pos;
   logic                   failed_ff, failed_in, cur_failed;
   logic [7:0]             b;
   logic [7:0]             folded;
   logic [2:0]             st;
   logic [MK_W-1:0]        mk;

   assign b      = req.data_byte;
   assign folded = is_upper(b) ? (b | CASE_BIT) : b;

   always_comb begin
      if (req.restart) begin
         cur_state  = S_LINE_START;
         cur_mbytes = '0;
         cur_mlen   = '0;
         cur_pend   = '0;
         cur_found  = '0;
         cur_pos    = '0;
         cur_failed = 1'b0;
      end else begin
         cur_state  = state_ff;
         cur_mbytes = mbytes_ff;
         cur_mlen   = mlen_ff;
         cur_pend   = pend_ff;
         cur_found  = found_ff;
         cur_pos    = pos_ff;
         cur_failed = failed_ff;
      end
   end

   always_comb begin
      kept_mbytes = cur_mbytes;
      for (int i = 0; i < MAX_METHOD_LEN; i++) begin
         if (cur_mlen == ML_W'(i)) begin
            kept_mbytes[8*i +: 8] = cur_mbytes[8*i +: 8] | folded;
         end
      end
      kept_mlen = (cur_mlen <= ML_W'(MAX_METHOD_LEN)) ? cur_mlen + 1'b1 : cur_mlen;
   end

   always_comb begin
      match_code = '0;
      for (int m = hrhp_pkg::METHOD_COUNT - 1; m >= 0; m--) begin
         if ((cur_mlen == ML_W'(hrhp_pkg::METHOD_LENS[m]))
             && (cur_mbytes == hrhp_pkg::METHOD_WORDS[m][MB_W-1:0])) begin
            match_code = 4'(m + 1);
         end
      end
   end

   always_comb begin
      st        = hrhp_pkg::ST_MORE;
      mk        = cur_pend;
      pend_in   = '0;
      state_in  = cur_state;
      mbytes_in = cur_mbytes;
      mlen_in   = cur_mlen;
      found_in  = cur_found;
      failed_in = cur_failed;

      unique case (cur_state)
         S_LINE_START: begin
            if (b == CH_CR || b == CH_LF) begin
               st = hrhp_pkg::ST_MORE;
            end else if (!is_upper(b)) begin
               st = hrhp_pkg::ST_FAIL;
            end else begin
               mbytes_in = kept_mbytes;
               mlen_in   = kept_mlen;
               mk        = mk | ms(FK_METHOD);
               state_in  = S_METHOD;
            end
         end
         S_METHOD: begin
            if (b != CH_SP) begin
               mbytes_in = kept_mbytes;
               mlen_in   = kept_mlen;
            end else begin
               found_in = match_code;
               if (match_code == '0) begin
                  st = hrhp_pkg::ST_FAIL;
               end else begin
                  mk       = mk | me(FK_METHOD);
                  state_in = S_AFTER_METHOD;
               end
            end
         end
         S_AFTER_METHOD: begin
            if (b == CH_SLASH) begin
               mk = mk | ms(FK_URI) | ms(FK_SCHEMA) | me(FK_SCHEMA) | ms(FK_HOST)
                  | me(FK_HOST) | ms(FK_PORT) | me(FK_PORT) | ms(FK_PATH);
               state_in = S_PATH;
            end else if (!is_alpha(b)) begin
               st = hrhp_pkg::ST_FAIL;
            end else begin
               mk       = mk | ms(FK_URI) | ms(FK_SCHEMA);
               state_in = S_SCHEMA;
            end
         end
         S_SCHEMA: begin
            if (b == CH_COLON) begin
               mk       = mk | me(FK_SCHEMA);
               state_in = S_SLASH1;
            end else if (!is_alpha(b)) begin
               st = hrhp_pkg::ST_FAIL;
            end
         end
         S_SLASH1: begin
            if (b != CH_SLASH) st = hrhp_pkg::ST_FAIL;
            else state_in = S_SLASH2;
         end
         S_SLASH2: begin
            if (b != CH_SLASH) begin
               st = hrhp_pkg::ST_FAIL;
            end else begin
               pend_in  = ms(FK_HOST);
               state_in = S_HOST;
            end
         end
         S_HOST: begin
            if (b == CH_COLON) begin
               mk       = mk | me(FK_HOST);
               pend_in  = ms(FK_PORT);
               state_in = S_PORT;
            end else if (b == CH_SLASH) begin
               mk       = mk | me(FK_HOST) | ms(FK_PORT) | me(FK_PORT) | ms(FK_PATH);
               state_in = S_PATH;
            end else if (b == CH_SP) begin
               mk = mk | me(FK_HOST) | ms(FK_PORT) | me(FK_PORT) | ms(FK_PATH)
                  | me(FK_PATH) | me(FK_URI);
               state_in = S_VER_START;
            end else if (!is_alpha(b) && !is_digit(b) && b != 8'h2D && b != 8'h2E) begin
               st = hrhp_pkg::ST_FAIL;
            end
         end
         S_PORT: begin
            if (b == CH_SLASH) begin
               mk       = mk | me(FK_PORT) | ms(FK_PATH);
               state_in = S_PATH;
            end else if (b == CH_SP) begin
               mk       = mk | me(FK_PORT) | ms(FK_PATH) | me(FK_PATH) | me(FK_URI);
               state_in = S_VER_START;
            end else if (!is_digit(b)) begin
               st = hrhp_pkg::ST_FAIL;
            end
         end
         S_PATH: begin
            if (b == CH_SP) begin
               mk       = mk | me(FK_PATH) | me(FK_URI);
               state_in = S_VER_START;
            end else if (b == 8'h3F || b == 8'h26 || b == 8'h3D || b == 8'h23) begin
               mk       = mk | me(FK_PATH) | ms(FK_QUERY);
               state_in = S_QUERY;
            end else if (b == CH_CR || b == CH_LF) begin
               st = hrhp_pkg::ST_FAIL;
            end
         end
         S_QUERY: begin
            if (b == CH_SP) begin
               mk       = mk | me(FK_QUERY) | me(FK_URI);
               state_in = S_VER_START;
            end else if (b == CH_CR || b == CH_LF) begin
               st = hrhp_pkg::ST_FAIL;
            end
         end
         S_VER_START: begin
            if (b == 8'h48) begin
               mk       = mk | ms(FK_VERSION);
               state_in = S_VER_H;
            end else if (b != CH_SP) begin
               st = hrhp_pkg::ST_FAIL;
            end
         end
         S_VER_H: begin
            if (b != 8'h54) st = hrhp_pkg::ST_FAIL;
            else state_in = S_VER_HT;
         end
         S_VER_HT: begin
            if (b != 8'h54) st = hrhp_pkg::ST_FAIL;
            else state_in = S_VER_HTT;
         end
         S_VER_HTT: begin
            if (b != 8'h50) st = hrhp_pkg::ST_FAIL;
            else state_in = S_VER_HTTP;
         end
         S_VER_HTTP: begin
            if (b != CH_SLASH) st = hrhp_pkg::ST_FAIL;
            else state_in = S_VER_SLASH;
         end
         S_VER_SLASH: begin
            if (b != 8'h31) st = hrhp_pkg::ST_FAIL;
            else state_in = S_VER_MAJOR;
         end
         S_VER_MAJOR: begin
            if (b != 8'h2E) st = hrhp_pkg::ST_FAIL;
            else state_in = S_VER_DOT;
         end
         S_VER_DOT: begin
            if (b != 8'h30 && b != 8'h31) st = hrhp_pkg::ST_FAIL;
            else state_in = S_VER_MINOR;
         end
         S_VER_MINOR: begin
            if (b == CH_CR) begin
               mk       = mk | me(FK_VERSION);
               state_in = S_LINE_CR;
            end else if (b == CH_LF) begin
               mk       = mk | me(FK_VERSION);
               state_in = S_AFTER_LF;
               st       = hrhp_pkg::ST_LINE;
            end else begin
               st = hrhp_pkg::ST_FAIL;
            end
         end
         S_LINE_CR: begin
            if (b != CH_LF) begin
               st = hrhp_pkg::ST_FAIL;
            end else begin
               state_in = S_AFTER_LF;
               st       = hrhp_pkg::ST_LINE;
            end
         end
         S_AFTER_LF: begin
            if (b == CH_LF) begin
               st = hrhp_pkg::ST_HEAD;
            end else if (b == CH_CR) begin
               state_in = S_BLANK_CR;
            end else if (!is_alpha(b)) begin
               st = hrhp_pkg::ST_FAIL;
            end else begin
               mk       = mk | ms(FK_KEY);
               state_in = S_KEY;
            end
         end
         S_BLANK_CR: begin
            st = (b == CH_LF) ? hrhp_pkg::ST_HEAD : hrhp_pkg::ST_FAIL;
         end
         S_KEY: begin
            if (b == CH_COLON) begin
               mk       = mk | me(FK_KEY);
               state_in = S_COLON;
            end else if (!is_alpha(b) && !is_digit(b) && b != 8'h2D && b != 8'h5F) begin
               st = hrhp_pkg::ST_FAIL;
            end
         end
         S_COLON, S_COLON_SP: begin
            // A value byte right after the colon or its spaces is handled as
            // the first byte of the value.
            if (b == CH_SP) begin
               state_in = S_COLON_SP;
            end else if (b == CH_CR) begin
               mk       = mk | ms(FK_VALUE) | me(FK_VALUE);
               state_in = S_VAL_CR;
            end else if (b == CH_LF) begin
               mk       = mk | ms(FK_VALUE) | me(FK_VALUE);
               state_in = S_AFTER_LF;
               st       = hrhp_pkg::ST_HDR;
            end else begin
               mk       = mk | ms(FK_VALUE);
               state_in = S_VALUE;
            end
         end
         S_VALUE: begin
            if (b == CH_CR) begin
               mk       = mk | me(FK_VALUE);
               state_in = S_VAL_CR;
            end else if (b == CH_LF) begin
               mk       = mk | me(FK_VALUE);
               state_in = S_AFTER_LF;
               st       = hrhp_pkg::ST_HDR;
            end
         end
         S_VAL_CR: begin
            if (b != CH_LF) begin
               st = hrhp_pkg::ST_FAIL;
            end else begin
               state_in = S_AFTER_LF;
               st       = hrhp_pkg::ST_HDR;
            end
         end
         default: begin
            st = hrhp_pkg::ST_FAIL;
         end
      endcase

      if (cur_failed) begin
         st        = hrhp_pkg::ST_FAIL;
         mk        = '0;
         pend_in   = cur_pend;
         state_in  = cur_state;
         mbytes_in = cur_mbytes;
         mlen_in   = cur_mlen;
         found_in  = cur_found;
      end else if (st == hrhp_pkg::ST_FAIL) begin
         failed_in = 1'b1;
         mk        = '0;
         pend_in   = '0;
      end

      result.status         = st;
      result.method_code    = found_in;
      result.byte_offset    = hrhp_pkg::OFFSET_PORT_BITS'(cur_pos);
      result.boundary_marks = mk;

      pos_in = (cur_pos != '1) ? cur_pos + 1'b1 : cur_pos;

      if (st == hrhp_pkg::ST_HEAD) begin
         state_in  = S_LINE_START;
         mbytes_in = '0;
         mlen_in   = '0;
         pend_in   = '0;
         found_in  = '0;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LINE_START;
         mbytes_ff <= '0;
         mlen_ff   <= '0;
         pend_ff   <= '0;
         found_ff  <= '0;
         pos_ff    <= '0;
         failed_ff <= 1'b0;
      end else if (step) begin
         state_ff  <= state_in;
         mbytes_ff <= mbytes_in;
         mlen_ff   <= mlen_in;
         pend_ff   <= pend_in;
         found_ff  <= found_in;
         pos_ff    <= pos_in;
         failed_ff <= failed_in;
      end
   end

endmodule

@@ hw/rtl/http_request_head_parser.sv @@
// ----------------------------------------------------------------------------
// HTTP request head parser
// Byte-wide request line and header line parser with a registered result.
// ----------------------------------------------------------------------------
// The req channel carries one byte of a request head per item, with a restart
// flag that begins a new request at that byte. The rsp channel returns exactly
// one item per byte: status, method code, byte offset and boundary marks.
// Both channels use valid/ready; an item moves when both are high.
// The result of a byte is registered: it is valid in the cycle after the
// byte is accepted. One byte is accepted every cycle, unless the receiver
// stalls with a result pending.
// The result sits in an output register; a new byte is taken while the
// receiver is ready or the register is empty. When the receiver stalls with
// a result pending, req_ready drops and the parse state holds.
// Synchronous reset puts the parser at the start of a request line, clears
// the error flag and empties the output register.
// ----------------------------------------------------------------------------
module http_request_head_parser #(
   parameter int OFFSET_BITS    = hrhp_pkg::OFFSET_BITS_DEFAULT,
   parameter int MAX_METHOD_LEN = hrhp_pkg::MAX_METHOD_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hrhp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hrhp_pkg::rsp_type rsp_data
);

   logic              accept;
   logic              rsp_valid_ff, rsp_valid_in;
   hrhp_pkg::rsp_type rsp_data_ff;
   hrhp_pkg::rsp_type result;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   hrhp_parser #(
      .OFFSET_BITS    (OFFSET_BITS),
      .MAX_METHOD_LEN (MAX_METHOD_LEN)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .req    (req_data),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sim/head_parse_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP request head parser checker
// Watches both channels of the head parser. Each accepted byte is run through
// a local model of the parse state machine, and the predicted result waits in
// order until the parser returns its result, which is compared field by field.
// ----------------------------------------------------------------------------
module head_parse_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  hrhp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  hrhp_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                waiting_count
);

   localparam int METHOD_LIMIT = hrhp_pkg::MAX_METHOD_LEN_DEFAULT;
   localparam logic [15:0] OFFSET_TOP = 16'hFFFF;

   localparam logic [3:0] M_NONE    = 4'd0;
   localparam logic [3:0] M_GET     = 4'd1;
   localparam logic [3:0] M_POST    = 4'd2;
   localparam logic [3:0] M_PUT     = 4'd3;
   localparam logic [3:0] M_HEAD    = 4'd4;
   localparam logic [3:0] M_DELETE  = 4'd5;
   localparam logic [3:0] M_OPTIONS = 4'd6;
   localparam logic [3:0] M_TRACE   = 4'd7;
   localparam logic [3:0] M_CONNECT = 4'd8;

   localparam int F_METHOD  = 0;
   localparam int F_URI     = 1;
   localparam int F_SCHEMA  = 2;
   localparam int F_HOST    = 3;
   localparam int F_PORT    = 4;
   localparam int F_PATH    = 5;
   localparam int F_QUERY   = 6;
   localparam int F_VERSION = 7;
   localparam int F_KEY     = 8;
   localparam int F_VALUE   = 9;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CASE_BIT = 8'h20;

   typedef enum logic [4:0] {
      PS_LINE_START, PS_METHOD, PS_AFTER_METHOD, PS_SCHEMA, PS_SLASH1, PS_SLASH2,
      PS_HOST, PS_PORT, PS_PATH, PS_QUERY, PS_VER_START, PS_VER_H, PS_VER_HT,
      PS_VER_HTT, PS_VER_HTTP, PS_VER_SLASH, PS_VER_MAJOR, PS_VER_DOT, PS_VER_MINOR,
      PS_LINE_CR, PS_KEY, PS_COLON, PS_COLON_SP, PS_VALUE, PS_VAL_CR, PS_AFTER_LF,
      PS_BLANK_CR
   } parse_phase_type;

   parse_phase_type phase = PS_LINE_START;
   logic [63:0]     method_word = '0;
   int              word_len = 0;
   logic [19:0]     marks_due = '0;
   logic [3:0]      method_found = M_NONE;
   logic [15:0]     offset_count = '0;
   logic            sticky_fail = 1'b0;

   hrhp_pkg::rsp_type expected_results[$];
   hrhp_pkg::rsp_type want;
   int                fail_tally = 0;
   int                queued = 0;

   assign mismatch_count = fail_tally;
   assign waiting_count  = queued;

   function automatic logic [19:0] opens(int k);
      return 20'd1 << (2 * k);
   endfunction

   function automatic logic [19:0] closes(int k);
      return 20'd1 << (2 * k + 1);
   endfunction

   function automatic logic is_upper(logic [7:0] b);
      return b >= "A" && b <= "Z";
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return is_upper(b) || (b >= "a" && b <= "z");
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic [7:0] fold(logic [7:0] b);
      return is_upper(b) ? (b | CASE_BIT) : b;
   endfunction

   function automatic string method_text(logic [3:0] code);
      case (code)
         M_GET:     return "get";
         M_POST:    return "post";
         M_PUT:     return "put";
         M_HEAD:    return "head";
         M_DELETE:  return "delete";
         M_OPTIONS: return "options";
         M_TRACE:   return "trace";
         M_CONNECT: return "connect";
         default:   return "";
      endcase
   endfunction

   function automatic logic [63:0] text_word(string s);
      logic [63:0] w;
      w = '0;
      for (int i = 0; i < s.len(); i++) w[8*i +: 8] = s[i];
      return w;
   endfunction

   function automatic logic [3:0] lookup_method(logic [63:0] word, int len);
      string name;
      if (len > METHOD_LIMIT) return M_NONE;
      for (int c = M_GET; c <= M_CONNECT; c++) begin
         name = method_text(4'(c));
         if (name.len() == len && text_word(name) == word) return 4'(c);
      end
      return M_NONE;
   endfunction

   task automatic start_request();
      phase        = PS_LINE_START;
      method_word  = '0;
      word_len     = 0;
      marks_due    = '0;
      method_found = M_NONE;
      offset_count = '0;
   endtask

   task automatic keep_method_byte(input logic [7:0] b);
      if (word_len < METHOD_LIMIT) method_word[8*word_len +: 8] = fold(b);
      if (word_len <= METHOD_LIMIT) word_len++;
   endtask

   task automatic parse_byte(input logic [7:0] b, inout logic [19:0] mk,
                             output logic [2:0] st);
      st = hrhp_pkg::ST_MORE;
      // The first byte after the colon spaces opens the value and is parsed as value.
      if ((phase == PS_COLON || phase == PS_COLON_SP) && b != CH_SP) begin
         mk |= opens(F_VALUE);
         phase = PS_VALUE;
      end
      case (phase)
         PS_LINE_START: begin
            if (b == CH_CR || b == CH_LF) st = hrhp_pkg::ST_MORE;
            else if (!is_upper(b)) st = hrhp_pkg::ST_FAIL;
            else begin
               keep_method_byte(b);
               mk |= opens(F_METHOD);
               phase = PS_METHOD;
            end
         end
         PS_METHOD: begin
            if (b != CH_SP) keep_method_byte(b);
            else begin
               method_found = lookup_method(method_word, word_len);
               if (method_found == M_NONE) st = hrhp_pkg::ST_FAIL;
               else begin
                  mk |= closes(F_METHOD);
                  phase = PS_AFTER_METHOD;
               end
            end
         end
         PS_AFTER_METHOD: begin
            if (b == "/") begin
               mk |= opens(F_URI) | opens(F_SCHEMA) | closes(F_SCHEMA) | opens(F_HOST)
                   | closes(F_HOST) | opens(F_PORT) | closes(F_PORT) | opens(F_PATH);
               phase = PS_PATH;
            end else if (!is_alpha(b)) st = hrhp_pkg::ST_FAIL;
            else begin
               mk |= opens(F_URI) | opens(F_SCHEMA);
               phase = PS_SCHEMA;
            end
         end
         PS_SCHEMA: begin
            if (b == ":") begin
               mk |= closes(F_SCHEMA);
               phase = PS_SLASH1;
            end else if (!is_alpha(b)) st = hrhp_pkg::ST_FAIL;
         end
         PS_SLASH1: begin
            if (b == "/") phase = PS_SLASH2;
            else st = hrhp_pkg::ST_FAIL;
         end
         PS_SLASH2: begin
            if (b == "/") begin
               marks_due |= opens(F_HOST);
               phase = PS_HOST;
            end else st = hrhp_pkg::ST_FAIL;
         end
         PS_HOST: begin
            if (b == ":") begin
               mk |= closes(F_HOST);
               marks_due |= opens(F_PORT);
               phase = PS_PORT;
            end else if (b == "/") begin
               mk |= closes(F_HOST) | opens(F_PORT) | closes(F_PORT) | opens(F_PATH);
               phase = PS_PATH;
            end else if (b == CH_SP) begin
               mk |= closes(F_HOST) | opens(F_PORT) | closes(F_PORT) | opens(F_PATH)
                   | closes(F_PATH) | closes(F_URI);
               phase = PS_VER_START;
            end else if (!is_alpha(b) && !is_digit(b) && b != "-" && b != ".") begin
               st = hrhp_pkg::ST_FAIL;
            end
         end
         PS_PORT: begin
            if (b == "/") begin
               mk |= closes(F_PORT) | opens(F_PATH);
               phase = PS_PATH;
            end else if (b == CH_SP) begin
               mk |= closes(F_PORT) | opens(F_PATH) | closes(F_PATH) | closes(F_URI);
               phase = PS_VER_START;
            end else if (!is_digit(b)) st = hrhp_pkg::ST_FAIL;
         end
         PS_PATH: begin
            if (b == CH_SP) begin
               mk |= closes(F_PATH) | closes(F_URI);
               phase = PS_VER_START;
            end else if (b == "?" || b == "&" || b == "=" || b == "#") begin
               mk |= closes(F_PATH) | opens(F_QUERY);
               phase = PS_QUERY;
            end else if (b == CH_CR || b == CH_LF) st = hrhp_pkg::ST_FAIL;
         end
         PS_QUERY: begin
            if (b == CH_SP) begin
               mk |= closes(F_QUERY) | closes(F_URI);
               phase = PS_VER_START;
            end else if (b == CH_CR || b == CH_LF) st = hrhp_pkg::ST_FAIL;
         end
         PS_VER_START: begin
            if (b == "H") begin
               mk |= opens(F_VERSION);
               phase = PS_VER_H;
            end else if (b != CH_SP) st = hrhp_pkg::ST_FAIL;
         end
         PS_VER_H: begin
            if (b == "T") phase = PS_VER_HT;
            else st = hrhp_pkg::ST_FAIL;
         end
         PS_VER_HT: begin
            if (b == "T") phase = PS_VER_HTT;
            else st = hrhp_pkg::ST_FAIL;
         end
         PS_VER_HTT: begin
            if (b == "P") phase = PS_VER_HTTP;
            else st = hrhp_pkg::ST_FAIL;
         end
         PS_VER_HTTP: begin
            if (b == "/") phase = PS_VER_SLASH;
            else st = hrhp_pkg::ST_FAIL;
         end
         PS_VER_SLASH: begin
            if (b == "1") phase = PS_VER_MAJOR;
            else st = hrhp_pkg::ST_FAIL;
         end
         PS_VER_MAJOR: begin
            if (b == ".") phase = PS_VER_DOT;
            else st = hrhp_pkg::ST_FAIL;
         end
         PS_VER_DOT: begin
            if (b == "0" || b == "1") phase = PS_VER_MINOR;
            else st = hrhp_pkg::ST_FAIL;
         end
         PS_VER_MINOR: begin
            if (b == CH_CR) begin
               mk |= closes(F_VERSION);
               phase = PS_LINE_CR;
            end else if (b == CH_LF) begin
               mk |= closes(F_VERSION);
               phase = PS_AFTER_LF;
               st = hrhp_pkg::ST_LINE;
            end else st = hrhp_pkg::ST_FAIL;
         end
         PS_LINE_CR: begin
            if (b == CH_LF) begin
               phase = PS_AFTER_LF;
               st = hrhp_pkg::ST_LINE;
            end else st = hrhp_pkg::ST_FAIL;
         end
         PS_AFTER_LF: begin
            if (b == CH_LF) st = hrhp_pkg::ST_HEAD;
            else if (b == CH_CR) phase = PS_BLANK_CR;
            else if (!is_alpha(b)) st = hrhp_pkg::ST_FAIL;
            else begin
               mk |= opens(F_KEY);
               phase = PS_KEY;
            end
         end
         PS_BLANK_CR: begin
            st = (b == CH_LF) ? hrhp_pkg::ST_HEAD : hrhp_pkg::ST_FAIL;
         end
         PS_KEY: begin
            if (b == ":") begin
               mk |= closes(F_KEY);
               phase = PS_COLON;
            end else if (!is_alpha(b) && !is_digit(b) && b != "-" && b != "_") begin
               st = hrhp_pkg::ST_FAIL;
            end
         end
         PS_COLON, PS_COLON_SP: begin
            phase = PS_COLON_SP;
         end
         PS_VALUE: begin
            if (b == CH_CR) begin
               mk |= closes(F_VALUE);
               phase = PS_VAL_CR;
            end else if (b == CH_LF) begin
               mk |= closes(F_VALUE);
               phase = PS_AFTER_LF;
               st = hrhp_pkg::ST_HDR;
            end
         end
         PS_VAL_CR: begin
            if (b == CH_LF) begin
               phase = PS_AFTER_LF;
               st = hrhp_pkg::ST_HDR;
            end else st = hrhp_pkg::ST_FAIL;
         end
         default: st = hrhp_pkg::ST_FAIL;
      endcase
   endtask

   task automatic predict_byte(input hrhp_pkg::req_type item,
                               output hrhp_pkg::rsp_type res);
      logic [19:0] mk;
      logic [2:0]  st;
      if (item.restart) begin
         start_request();
         sticky_fail = 1'b0;
      end
      res.byte_offset = offset_count;
      mk = '0;
      st = hrhp_pkg::ST_FAIL;
      if (!sticky_fail) begin
         mk = marks_due;
         marks_due = '0;
         parse_byte(item.data_byte, mk, st);
         if (st == hrhp_pkg::ST_FAIL) begin
            sticky_fail = 1'b1;
            mk = '0;
            marks_due = '0;
         end
      end
      res.status         = st;
      res.method_code    = method_found;
      res.boundary_marks = mk;
      if (offset_count != OFFSET_TOP) offset_count++;
      if (st == hrhp_pkg::ST_HEAD) start_request();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         start_request();
         sticky_fail = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (fail_tally < 10)
                  $display("%0t: result with no byte outstanding: %s%0d %0d %0d %05h",
                           $realtime, "st/code/off/marks=", rsp_data.status,
                           rsp_data.method_code, rsp_data.byte_offset,
                           rsp_data.boundary_marks);
               fail_tally++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.status !== want.status
                   || rsp_data.method_code !== want.method_code
                   || rsp_data.byte_offset !== want.byte_offset
                   || rsp_data.boundary_marks !== want.boundary_marks) begin
                  if (fail_tally < 10)
                     $display("%0t: mismatch: want st=%0d code=%0d off=%0d marks=%05h,%s",
                              $realtime, want.status, want.method_code, want.byte_offset,
                              want.boundary_marks, " got");
                  if (fail_tally < 10)
                     $display("   st=%0d code=%0d off=%0d marks=%05h",
                              rsp_data.status, rsp_data.method_code,
                              rsp_data.byte_offset, rsp_data.boundary_marks);
                  fail_tally++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_byte(req_data, want);
            expected_results.push_back(want);
         end
      end
      queued <= expected_results.size();
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP request head parser testbench
// Feeds the parser directed heads, random well-formed heads with random
// content, damaged heads and byte noise, with restarts at the start and in
// the middle of heads, under several sender idle and receiver stall mixes.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_BYTES = 500;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_SP = 8'h20;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   hrhp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   hrhp_pkg::rsp_type rsp_data;

   int          mismatches;
   int          waiting;
   int          sender_idle_pct = 0;
   int          stall_pct = 0;
   int          quiet = 0;
   int          bytes_sent = 0;
   int          heads_made = 0;
   int          heads_clean = 0;
   logic        need_restart = 1'b0;
   logic [7:0]  head_bytes[$];

   http_request_head_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   head_parse_checker head_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatches),
      .waiting_count  (waiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", quiet);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic logic [7:0] pick_char(string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   function automatic logic [7:0] mixed_case(logic [7:0] c);
      if (c >= "a" && c <= "z" && $urandom_range(1)) return c ^ 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] path_char();
      logic [7:0] c;
      do begin
         c = $urandom_range(1) ? 8'($urandom_range(33, 126)) : 8'($urandom_range(255));
      end while (c == CH_SP || c == CH_CR || c == CH_LF
                 || c == "?" || c == "&" || c == "=" || c == "#");
      return c;
   endfunction

   function automatic logic [7:0] line_char(logic allow_space);
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == CH_CR || c == CH_LF || (!allow_space && c == CH_SP));
      return c;
   endfunction

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) head_bytes.push_back(s[i]);
   endtask

   task automatic put_run(input int n, input string set);
      repeat (n) head_bytes.push_back(pick_char(set));
   endtask

   task automatic put_eol();
      if ($urandom_range(1)) head_bytes.push_back(CH_CR);
      head_bytes.push_back(CH_LF);
   endtask

   task automatic put_path();
      head_bytes.push_back("/");
      repeat ($urandom_range(0, 10)) head_bytes.push_back(path_char());
      if ($urandom_range(1)) begin
         put_run(1, "?&=#");
         repeat ($urandom_range(0, 10)) head_bytes.push_back(line_char(1'b0));
      end
   endtask

   task automatic build_head();
      string name;
      head_bytes.delete();
      if ($urandom_range(7) == 0) put_eol();
      case ($urandom_range(7))
         0:       name = "get";
         1:       name = "post";
         2:       name = "put";
         3:       name = "head";
         4:       name = "delete";
         5:       name = "options";
         6:       name = "trace";
         default: name = "connect";
      endcase
      head_bytes.push_back(name[0] ^ 8'h20);
      for (int i = 1; i < name.len(); i++) head_bytes.push_back(mixed_case(name[i]));
      head_bytes.push_back(CH_SP);
      if ($urandom_range(2) == 0) begin
         put_path();
      end else begin
         repeat ($urandom_range(1, 6))
            head_bytes.push_back(mixed_case(pick_char("abcdefghijklmnopqrstuvwxyz")));
         put_text("://");
         put_run($urandom_range(0, 8),
                 "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-.");
         if ($urandom_range(1)) begin
            put_text(":");
            put_run($urandom_range(0, 5), "0123456789");
         end
         if ($urandom_range(2) != 0) put_path();
      end
      put_run($urandom_range(1, 2), " ");
      put_text("HTTP/1.");
      put_run(1, "01");
      put_eol();
      repeat ($urandom_range(0, 4)) begin
         head_bytes.push_back(mixed_case(pick_char("abcdefghijklmnopqrstuvwxyz")));
         put_run($urandom_range(0, 8),
                 "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_");
         put_text(":");
         put_run($urandom_range(0, 2), " ");
         repeat ($urandom_range(0, 12)) head_bytes.push_back(line_char(1'b1));
         put_eol();
      end
      put_eol();
   endtask

   task automatic damage_head();
      int pos;
      pos = $urandom_range(head_bytes.size() - 1);
      case ($urandom_range(2))
         0: head_bytes[pos] = 8'($urandom_range(255));
         1: while (head_bytes.size() > pos + 1) void'(head_bytes.pop_back());
         default: head_bytes.insert(pos, 8'($urandom_range(255)));
      endcase
   endtask

   task automatic send_item(input logic [7:0] b, input logic r);
      hrhp_pkg::req_type item;
      item.data_byte = b;
      item.restart   = r;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_head(input logic first_restart, input int restart_at);
      for (int i = 0; i < head_bytes.size(); i++)
         send_item(head_bytes[i], (i == 0 && first_restart) || i == restart_at);
      heads_made++;
   endtask

   // Holds the sender off until the parser has returned every result.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (waiting != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int idle, input int stall);
      int   start;
      int   kind;
      int   cut;
      logic first;
      sender_idle_pct = idle;
      stall_pct = stall;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
         kind  = $urandom_range(9);
         first = need_restart || ($urandom_range(3) == 0);
         cut   = -1;
         if (kind < 7) begin
            build_head();
            need_restart = 1'b0;
            if ($urandom_range(15) == 0) begin
               cut = $urandom_range(1, head_bytes.size() - 1);
               need_restart = 1'b1;
            end else begin
               heads_clean++;
            end
         end else if (kind < 9) begin
            build_head();
            damage_head();
            need_restart = 1'b1;
         end else begin
            head_bytes.delete();
            repeat ($urandom_range(1, 16)) head_bytes.push_back(8'($urandom_range(255)));
            need_restart = 1'b1;
         end
         send_head(first, cut);
      end
      drain();
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Leading LF, query, empty header value, CRLF ends.
      head_bytes.delete();
      put_text("\nPUT /?a HTTP/1.0\015\nk:\015\n\015\n");
      send_head(1'b0, -1);
      // Extreme bytes: failure, then a sticky failure.
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b0);
      // Eight-letter method fails at the space.
      head_bytes.delete();
      put_text("OPTIONSX ");
      send_head(1'b1, -1);
      need_restart = 1'b1;
      drain();

      // A clean head after a restart.
      build_head();
      send_head(1'b1, -1);
      need_restart = 1'b0;

      run_phase(0, 0);
      run_phase(73, 0);
      run_phase(0, 73);
      run_phase(18, 18);

      drain();
      repeat (4) @(negedge clock);
      $display("Sent %0d bytes in %0d heads (%0d clean), with damaged heads, noise, restarts",
               bytes_sent, heads_made, heads_clean);
      $display("under free flow, sender gaps, receiver stalls and both mixed.");
      if (mismatches == 0 && waiting == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/hrhp_pkg.sv
hw/rtl/hrhp_parser.sv
hw/rtl/http_request_head_parser.sv
sim/head_parse_checker.sv
sim/tb.sv
